>>> rtl/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside of reset.
`define URX_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define URX_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/urxto_pkg.sv
// ----------------------------------------------------------------------------
// urxto_pkg
// Types and constants of the 8N1 receiver with timeout.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package urxto_pkg;

  localparam int TickW   = 16;
  localparam int ByteW   = 8;
  localparam int LimitW  = 32;
  localparam int WaitW   = 17;
  localparam int PollW   = 33;
  localparam int BitIdxW = 4;
  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 32;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_TICKS_PER_BIT = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_BYTE_TARGET   = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_TIMEOUT_TICKS = 2'd2;

  localparam logic [TickW-1:0]  RST_TICKS_PER_BIT = 16'd16;
  localparam logic [ByteW-1:0]  RST_BYTE_TARGET   = 8'd1;
  localparam logic [LimitW-1:0] RST_TIMEOUT_TICKS = 32'd100000;

  // opcodes
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_START = 1'b1;

  // result kinds
  localparam logic KIND_BYTE   = 1'b0;
  localparam logic KIND_FINISH = 1'b1;

  // phases
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_HUNT = 2'd1;
  localparam logic [1:0] PH_RECV = 2'd2;
  localparam logic [1:0] PH_WAIT = 2'd3;

  typedef struct packed {
    logic opcode;
    logic rx_level;
  } in_item_t;

  typedef struct packed {
    logic             kind;
    logic [ByteW-1:0] data;
    logic             success;
  } out_item_t;

  typedef struct packed {
    logic [TickW-1:0]  ticks_per_bit;
    logic [ByteW-1:0]  byte_target;
    logic [LimitW-1:0] timeout_ticks;
  } cfg_t;

endpackage

`default_nettype wire

>>> rtl/urxto_cfg.sv
// ----------------------------------------------------------------------------
// urxto_cfg
// Configuration registers, written through a plain write port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module urxto_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [urxto_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [urxto_pkg::CfgDataW-1:0] cfg_wdata,
  output urxto_pkg::cfg_t                     cfg
);

  urxto_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ticks_per_bit <= urxto_pkg::RST_TICKS_PER_BIT;
      cfg_r.byte_target   <= urxto_pkg::RST_BYTE_TARGET;
      cfg_r.timeout_ticks <= urxto_pkg::RST_TIMEOUT_TICKS;
    end else if (cfg_we) begin
      case (cfg_index)
        urxto_pkg::REG_TICKS_PER_BIT: begin
          cfg_r.ticks_per_bit <= cfg_wdata[urxto_pkg::TickW-1:0];
        end
        urxto_pkg::REG_BYTE_TARGET: begin
          cfg_r.byte_target <= cfg_wdata[urxto_pkg::ByteW-1:0];
        end
        urxto_pkg::REG_TIMEOUT_TICKS: begin
          cfg_r.timeout_ticks <= cfg_wdata[urxto_pkg::LimitW-1:0];
        end
        default: begin
          // unmapped index, dropped
        end
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

>>> rtl/urxto_core.sv
// ----------------------------------------------------------------------------
// urxto_core
// Receive state machine: hunt, bit sampling, stop wait and completion test.
// One tick per cycle while step is high; result goes out with the same edge.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module urxto_core (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire urxto_pkg::cfg_t      cfg,
  input  wire logic                 step,
  input  wire urxto_pkg::in_item_t  item,
  output logic                      res_valid,
  output urxto_pkg::out_item_t      res
);

  logic [1:0]                        phase_r, phase_nxt;
  logic [urxto_pkg::WaitW-1:0]       wait_r, wait_nxt;
  logic [urxto_pkg::BitIdxW-1:0]     bit_idx_r, bit_idx_nxt;
  logic [urxto_pkg::ByteW-1:0]       shift_r, shift_nxt;
  logic [urxto_pkg::ByteW-1:0]       nbytes_r, nbytes_nxt;
  logic [urxto_pkg::PollW-1:0]       poll_r, poll_nxt;

  logic                              wait_over;
  logic                              finish;
  logic [urxto_pkg::ByteW-1:0]       shift_upd;
  logic [urxto_pkg::BitIdxW-1:0]     bit_idx_inc;
  logic [urxto_pkg::WaitW-1:0]       tpb_ext;
  logic [urxto_pkg::WaitW:0]         tpb_x3;

  assign wait_over   = (wait_r <= urxto_pkg::WaitW'(1));
  assign finish      = (poll_r > {1'b0, cfg.timeout_ticks}) ||
                       (nbytes_r >= cfg.byte_target);
  assign shift_upd   = shift_r |
                       (urxto_pkg::ByteW'(item.rx_level) << bit_idx_r[2:0]);
  assign bit_idx_inc = bit_idx_r + urxto_pkg::BitIdxW'(1);
  assign tpb_ext     = urxto_pkg::WaitW'(cfg.ticks_per_bit);
  // 3P fits in 18 bits; half of it in 17
  assign tpb_x3      = {tpb_ext, 1'b0} + {1'b0, tpb_ext};

  always_comb begin
    phase_nxt   = phase_r;
    wait_nxt    = wait_r;
    bit_idx_nxt = bit_idx_r;
    shift_nxt   = shift_r;
    nbytes_nxt  = nbytes_r;
    poll_nxt    = poll_r;
    res_valid   = 1'b0;
    res         = '0;

    if (step) begin
      if (item.opcode == urxto_pkg::OP_START) begin
        phase_nxt   = urxto_pkg::PH_HUNT;
        wait_nxt    = '0;
        bit_idx_nxt = '0;
        shift_nxt   = '0;
        nbytes_nxt  = '0;
        poll_nxt    = '0;
      end else begin
        case (phase_r)
          urxto_pkg::PH_HUNT: begin
            if (finish) begin
              res_valid   = 1'b1;
              res.kind    = urxto_pkg::KIND_FINISH;
              res.success = (nbytes_r == cfg.byte_target);
              phase_nxt   = urxto_pkg::PH_IDLE;
            end else if (!item.rx_level) begin
              wait_nxt    = tpb_x3[urxto_pkg::WaitW:1];
              bit_idx_nxt = '0;
              shift_nxt   = '0;
              phase_nxt   = urxto_pkg::PH_RECV;
            end else begin
              poll_nxt = poll_r + urxto_pkg::PollW'(1);
            end
          end
          urxto_pkg::PH_RECV: begin
            if (!wait_over) begin
              wait_nxt = wait_r - urxto_pkg::WaitW'(1);
            end else begin
              shift_nxt   = shift_upd;
              bit_idx_nxt = bit_idx_inc;
              if (bit_idx_inc < urxto_pkg::BitIdxW'(8)) begin
                wait_nxt = tpb_ext;
              end else begin
                res_valid  = 1'b1;
                res.kind   = urxto_pkg::KIND_BYTE;
                res.data   = shift_upd;
                nbytes_nxt = nbytes_r + urxto_pkg::ByteW'(1);
                wait_nxt   = tpb_ext + urxto_pkg::WaitW'(1);
                phase_nxt  = urxto_pkg::PH_WAIT;
              end
            end
          end
          urxto_pkg::PH_WAIT: begin
            if (!wait_over) begin
              wait_nxt = wait_r - urxto_pkg::WaitW'(1);
            end else begin
              wait_nxt  = '0;
              poll_nxt  = poll_r + urxto_pkg::PollW'(1);
              phase_nxt = urxto_pkg::PH_HUNT;
            end
          end
          default: begin
            // idle: ticks are dropped
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= urxto_pkg::PH_IDLE;
      wait_r    <= '0;
      bit_idx_r <= '0;
      shift_r   <= '0;
      nbytes_r  <= '0;
      poll_r    <= '0;
    end else begin
      phase_r   <= phase_nxt;
      wait_r    <= wait_nxt;
      bit_idx_r <= bit_idx_nxt;
      shift_r   <= shift_nxt;
      nbytes_r  <= nbytes_nxt;
      poll_r    <= poll_nxt;
    end
  end

  `URX_ASSERT(a_res_needs_step, clk, rst_n, res_valid |-> step, "result without a beat")
  `URX_ASSERT(a_byte_from_recv, clk, rst_n, (res_valid && res.kind == urxto_pkg::KIND_BYTE) |-> (phase_r == urxto_pkg::PH_RECV && bit_idx_r == urxto_pkg::BitIdxW'(7)), "byte emitted outside last data bit")
  `URX_ASSERT(a_finish_to_idle, clk, rst_n, (res_valid && res.kind == urxto_pkg::KIND_FINISH) |=> (phase_r == urxto_pkg::PH_IDLE), "finish did not return to idle")

endmodule

`default_nettype wire

>>> rtl/urxto_obuf.sv
// ----------------------------------------------------------------------------
// urxto_obuf
// Result register plus one skid entry; keeps the input open while a
// finished result waits on the output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module urxto_obuf (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  push,
  input  wire urxto_pkg::out_item_t  push_item,
  output logic                       can_push,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output urxto_pkg::out_item_t       out_data
);

  logic                 out_valid_r, out_valid_nxt;
  logic                 skid_valid_r, skid_valid_nxt;
  urxto_pkg::out_item_t out_item_r, out_item_nxt;
  urxto_pkg::out_item_t skid_item_r, skid_item_nxt;
  logic                 out_take;

  assign out_take = out_valid_r && out_ready;
  assign can_push = !skid_valid_r;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_item_nxt   = out_item_r;
    skid_item_nxt  = skid_item_r;
    if (out_take) begin
      out_valid_nxt = 1'b0;
    end
    if (skid_valid_r && !out_valid_nxt) begin
      out_valid_nxt  = 1'b1;
      out_item_nxt   = skid_item_r;
      skid_valid_nxt = 1'b0;
    end
    if (push) begin
      if (!out_valid_nxt) begin
        out_valid_nxt = 1'b1;
        out_item_nxt  = push_item;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_item_nxt  = push_item;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_item_r  <= out_item_nxt;
    skid_item_r <= skid_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  `URX_ASSERT(a_skid_behind_out, clk, rst_n, skid_valid_r |-> out_valid_r, "skid full with empty output")
  `URX_ASSERT(a_no_push_when_full, clk, rst_n, push |-> can_push, "beat pushed into full buffer")
  `URX_ASSERT(a_skid_kept, clk, rst_n, (skid_valid_r && !out_take) |=> (skid_valid_r && $stable(skid_item_r)), "skid entry lost")

endmodule

`default_nettype wire

>>> rtl/uart_receiver_with_timeout_top.sv
// ----------------------------------------------------------------------------
// uart_receiver_with_timeout_top
// 8N1 serial receiver with poll timeout, driven by oversampling ticks.
//
// Channel  Dir  Handshake            Beat
// in_      in   in_valid/in_ready    opcode (tick or start), rx_level
// out_     out  out_valid/out_ready  kind (byte or finish), data, success
// cfg_     in   cfg_we               cfg_index selects register, cfg_wdata
//
// One tick per clock while in_ready is high; the state machine updates in the
// accept cycle; the result is registered in the result register or skid entry.
// in_ready drops only when both the result register and its skid entry
// hold results; it does not depend on out_ready combinationally.
// Reset is synchronous, active low; it loads the register defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module uart_receiver_with_timeout_top (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire urxto_pkg::in_item_t            in_data,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output urxto_pkg::out_item_t                out_data,
  input  wire logic                           cfg_we,
  input  wire logic [urxto_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [urxto_pkg::CfgDataW-1:0] cfg_wdata
);

  urxto_pkg::cfg_t      cfg;
  urxto_pkg::out_item_t res;
  logic                 res_valid;
  logic                 step;

  assign step = in_valid && in_ready;

  urxto_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  urxto_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .step      (step),
    .item      (in_data),
    .res_valid (res_valid),
    .res       (res)
  );

  urxto_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_item (res),
    .can_push  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

>>> tb/urxto_checker.sv
// ----------------------------------------------------------------------------
// urxto_checker
// Watches the tick, result and register ports of the 8N1 receiver, keeps
// its own copy of the receiver state, and compares every result beat,
// field by field, with the oldest predicted one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module urxto_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  urxto_pkg::in_item_t            in_data,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  urxto_pkg::out_item_t           out_data,
  input  logic                           cfg_we,
  input  logic [urxto_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [urxto_pkg::CfgDataW-1:0] cfg_wdata,
  output int                             mismatches,
  output int                             rx_owed,
  output int                             live_ticks
);
  import urxto_pkg::*;

  // register copies
  logic [TickW-1:0]   bit_ticks;
  logic [ByteW-1:0]   want_bytes;
  logic [LimitW-1:0]  poll_limit;

  // receiver state copy
  logic [1:0]         rx_phase;
  logic [WaitW-1:0]   tick_wait;
  logic [BitIdxW-1:0] bit_pos;
  logic [ByteW-1:0]   shifter;
  logic [ByteW-1:0]   got_bytes;
  logic [PollW-1:0]   polls;

  out_item_t          rx_due_q[$];
  out_item_t          owed_item;

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatches = mismatches + 1;
  endtask

  task automatic clear_counters();
    tick_wait = '0;
    bit_pos   = '0;
    shifter   = '0;
    got_bytes = '0;
    polls     = '0;
  endtask

  // one tick of a wait; a zero count still costs a tick
  function automatic bit wait_over();
    if (tick_wait <= 1) begin
      tick_wait = '0;
      return 1'b1;
    end
    tick_wait = tick_wait - 1'b1;
    return 1'b0;
  endfunction

  task automatic advance_receiver(input in_item_t beat);
    logic [17:0] three_halves;
    out_item_t   res;
    three_halves = 18'(bit_ticks) * 18'd3;
    res = '0;
    if (beat.opcode == OP_START) begin
      clear_counters();
      rx_phase = PH_HUNT;
    end else begin
      case (rx_phase)
        PH_HUNT: begin
          // completion is tested before the line is looked at
          if (polls > {1'b0, poll_limit} || got_bytes >= want_bytes) begin
            res.kind    = KIND_FINISH;
            res.success = (got_bytes == want_bytes);
            rx_due_q.push_back(res);
            rx_phase = PH_IDLE;
          end else if (!beat.rx_level) begin
            tick_wait = three_halves[17:1];
            bit_pos   = '0;
            shifter   = '0;
            rx_phase  = PH_RECV;
          end else begin
            polls = polls + 1'b1;
          end
        end
        PH_RECV: begin
          if (wait_over()) begin
            shifter[bit_pos[2:0]] = beat.rx_level;
            bit_pos = bit_pos + 1'b1;
            if (bit_pos < 8) begin
              tick_wait = WaitW'(bit_ticks);
            end else begin
              res.kind = KIND_BYTE;
              res.data = shifter;
              rx_due_q.push_back(res);
              got_bytes = got_bytes + 1'b1;
              tick_wait = WaitW'(bit_ticks) + 1'b1;
              rx_phase  = PH_WAIT;
            end
          end
        end
        PH_WAIT: begin
          if (wait_over()) begin
            polls    = polls + 1'b1;
            rx_phase = PH_HUNT;
          end
        end
        default: ;
      endcase
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      bit_ticks  = RST_TICKS_PER_BIT;
      want_bytes = RST_BYTE_TARGET;
      poll_limit = RST_TIMEOUT_TICKS;
      rx_phase   = PH_IDLE;
      clear_counters();
      rx_due_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (rx_due_q.size() == 0) begin
          report_mismatch($sformatf("result beat with nothing owed: kind %0d data %02h success %0d",
                                    out_data.kind, out_data.data, out_data.success));
        end else begin
          owed_item = rx_due_q.pop_front();
          if (out_data.kind !== owed_item.kind)
            report_mismatch($sformatf("kind got %0d want %0d", out_data.kind, owed_item.kind));
          if (out_data.data !== owed_item.data)
            report_mismatch($sformatf("data got %02h want %02h", out_data.data, owed_item.data));
          if (out_data.success !== owed_item.success)
            report_mismatch($sformatf("success got %0d want %0d",
                                      out_data.success, owed_item.success));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_TICKS_PER_BIT: bit_ticks  = cfg_wdata[TickW-1:0];
          REG_BYTE_TARGET:   want_bytes = cfg_wdata[ByteW-1:0];
          REG_TIMEOUT_TICKS: poll_limit = cfg_wdata[LimitW-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (in_data.opcode == OP_START || rx_phase != PH_IDLE)
          live_ticks = live_ticks + 1;
        advance_receiver(in_data);
      end
    end
    rx_owed <= rx_due_q.size();
  end

endmodule

>>> tb/tb_uart_receiver_with_timeout_top.sv
// ----------------------------------------------------------------------------
// tb_uart_receiver_with_timeout_top
// Drives serial line waveforms, tick by tick, into the 8N1 receiver across
// many register settings: clean frames, noisy and cut frames, timeouts and
// restarts. Both channels idle at random; one long result stall fills the
// block. The checker module does the prediction and comparison.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_uart_receiver_with_timeout_top;
  import urxto_pkg::*;

  localparam int ITEMS          = 800;
  localparam int HOLD_CYCLES    = 1200;
  localparam int WATCHDOG_LIMIT = 8000;
  localparam int SETTLE_CYCLES  = 4;
  localparam int MAX_PHASES     = 400;
  localparam logic [CfgIdxW-1:0] REG_SPARE = 2'd3;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  in_item_t            in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_item_t           out_data;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = REG_TICKS_PER_BIT;
  logic [CfgDataW-1:0] cfg_wdata = '0;

  int mismatches;
  int rx_owed;
  int live_ticks;
  int idle_cycles = 0;

  bit in_steady = 1'b0;
  bit out_steady = 1'b0;
  bit hold_req = 1'b0;
  bit hold_active = 1'b0;

  uart_receiver_with_timeout_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  urxto_checker u_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .mismatches   (mismatches),
    .rx_owed      (rx_owed),
    .live_ticks   (live_ticks)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
  end

  // no beat on either side for too long means the block is stuck
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // result side: random ready bursts, plus one long hold when asked
  initial begin
    int run;
    int stall;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ready   <= 1'b0;
        hold_active = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_active = 1'b0;
        hold_req    = 1'b0;
      end
      run   = $urandom_range(1, 40);
      stall = out_steady ? 0 : pick_gap();
      out_ready <= 1'b1;
      repeat (run) @(posedge clk);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  task automatic send_beat(input logic op, input logic rx);
    int       gap;
    in_item_t beat;
    gap = in_steady ? 0 : pick_gap();
    beat.opcode   = op;
    beat.rx_level = rx;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (!in_ready);
  endtask

  // line waveform of one 8N1 frame, optionally cut short and with glitches
  task automatic send_frame(input logic [7:0] value, input int bit_len, input bit noisy,
                            input int cut);
    int   total;
    int   slot;
    logic level;
    total = 10 * bit_len;
    if (cut > 0 && cut < total) total = cut;
    for (int t = 0; t < total; t++) begin
      slot = t / bit_len;
      if (slot == 0) level = 1'b0;
      else if (slot <= 8) level = value[slot-1];
      else level = 1'b1;
      if (noisy && $urandom_range(0, 29) == 0) level = ~level;
      send_beat(OP_TICK, level);
    end
  endtask

  // wait out every owed result, then rewrite all registers
  task automatic program_receiver(input int p, input int target, input logic [31:0] limit,
                                  input bit poke_spare);
    in_valid <= 1'b0;
    @(posedge clk);
    while (rx_owed != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_TICKS_PER_BIT;
    cfg_wdata <= {16'($urandom), p[15:0]};
    @(posedge clk);
    cfg_index <= REG_BYTE_TARGET;
    cfg_wdata <= {24'($urandom), target[7:0]};
    @(posedge clk);
    cfg_index <= REG_TIMEOUT_TICKS;
    cfg_wdata <= limit;
    @(posedge clk);
    if (poke_spare) begin
      cfg_index <= REG_SPARE;
      cfg_wdata <= $urandom;
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return 8'h00;
    if (r < 30) return 8'hFF;
    return 8'($urandom);
  endfunction

  task automatic random_transaction(input int p, input int target);
    int bit_len;
    int nframes;
    int hunt;
    int cut;
    bit broken;
    bit_len = (p < 1) ? 1 : p;
    hunt    = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 3);
    broken  = ($urandom_range(0, 9) == 0);
    if (p > 24) begin
      nframes = 0;
      broken  = 1'b1;
    end else if (p > 10) begin
      nframes = $urandom_range(0, 1);
    end else if (target > 4) begin
      nframes = $urandom_range(1, 4);
    end else begin
      nframes = target + $urandom_range(0, 1);
    end
    send_beat(OP_START, 1'($urandom));
    repeat (hunt) send_beat(OP_TICK, 1'b1);
    for (int i = 0; i < nframes; i++) begin
      send_frame(pick_byte(), bit_len, $urandom_range(0, 4) == 0, 0);
      repeat ($urandom_range(0, 3)) send_beat(OP_TICK, 1'b1);
    end
    if (broken) begin
      cut = $urandom_range(1, (10 * bit_len - 1 < 60) ? 10 * bit_len - 1 : 60);
      send_frame(pick_byte(), bit_len, $urandom_range(0, 1), cut);
    end else begin
      repeat ($urandom_range(1, 3)) send_beat(OP_TICK, 1'b1);
    end
  endtask

  initial begin
    int          phase_no;
    int          r;
    int          p;
    int          target;
    logic [31:0] limit;

    @(posedge clk);
    while (!rst_n) @(posedge clk);

    // ticks before any start are ignored
    send_beat(OP_TICK, 1'b0);
    send_beat(OP_TICK, 1'b1);

    // zero byte target ends on the first hunting tick, line level aside
    program_receiver(0, 0, 32'd0, 1'b1);
    send_beat(OP_START, 1'b1);
    send_beat(OP_TICK, 1'b0);

    // zero bit period: one tick per frame step
    program_receiver(0, 1, 32'hFFFF_FFFF, 1'b0);
    send_beat(OP_START, 1'b0);
    send_frame(8'hA5, 1, 1'b0, 0);
    send_beat(OP_TICK, 1'b1);

    // timeout with a zero limit
    program_receiver(1, 1, 32'd0, 1'b0);
    send_beat(OP_START, 1'b1);
    send_beat(OP_TICK, 1'b1);
    send_beat(OP_TICK, 1'b1);

    // longest bit period, restarted in the middle of a frame
    program_receiver(65535, 255, 32'hFFFF_FFFF, 1'b0);
    send_beat(OP_START, 1'b1);
    send_beat(OP_TICK, 1'b0);
    repeat (3) send_beat(OP_TICK, 1'b1);
    send_beat(OP_START, 1'b0);
    send_beat(OP_TICK, 1'b1);

    // result side holds off while finishes pile up and stall the input
    program_receiver(2, 0, 32'd0, 1'b0);
    hold_req  = 1'b1;
    in_steady = 1'b1;
    while (!hold_active) @(posedge clk);
    repeat (30) begin
      send_beat(OP_START, 1'($urandom));
      send_beat(OP_TICK, 1'($urandom));
    end
    in_steady = 1'b0;

    phase_no = 0;
    while (live_ticks < ITEMS && phase_no < MAX_PHASES) begin
      r = $urandom_range(0, 99);
      if (r < 8) p = $urandom_range(0, 1);
      else if (r < 70) p = $urandom_range(2, 4);
      else if (r < 88) p = $urandom_range(5, 10);
      else if (r < 96) p = $urandom_range(11, 24);
      else p = $urandom_range(25, 65535);

      r = $urandom_range(0, 99);
      if (r < 15) target = 0;
      else if (r < 60) target = $urandom_range(1, 2);
      else if (r < 80) target = $urandom_range(3, 4);
      else if (r < 90) target = 255;
      else target = $urandom_range(5, 254);

      r = $urandom_range(0, 99);
      if (r < 50) limit = 32'hFFFF_FFFF;
      else if (r < 75) limit = $urandom_range(0, 20);
      else if (r < 90) limit = $urandom;
      else limit = 32'd0;

      if (phase_no == 0) begin
        p      = 2;
        target = 255;
        limit  = 32'hFFFF_FFFF;
      end else if (phase_no == 1) begin
        p      = 3;
        target = 3;
        limit  = $urandom_range(0, 20);
      end

      program_receiver(p, target, limit, $urandom_range(0, 9) == 0);
      in_steady  = ($urandom_range(0, 4) == 0);
      out_steady = ($urandom_range(0, 4) == 0);
      repeat ($urandom_range(1, 4)) random_transaction(p, target);
      phase_no++;
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (rx_owed != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
